// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, character codes and the character classifier of the Base64 decoder.
package b64d_pkg;

  // Character classes produced by the front end.
  localparam logic [1:0] KIND_ALPHA = 2'd0;
  localparam logic [1:0] KIND_BLANK = 2'd1;
  localparam logic [1:0] KIND_PAD   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // Position within a group of four characters.
  localparam logic [2:0] POS_FIRST      = 3'd0;
  localparam logic [2:0] POS_SECOND     = 3'd1;
  localparam logic [2:0] POS_THIRD      = 3'd2;
  localparam logic [2:0] POS_FOURTH     = 3'd3;
  localparam logic [2:0] POS_SECOND_PAD = 3'd4;

  // ASCII codes that the classifier needs.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_SLASH   = 8'h2f;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_LF      = 8'h0a;
  localparam logic [7:0] CHAR_FF      = 8'h0c;
  localparam logic [7:0] CHAR_CR      = 8'h0d;

  // Offsets that map each alphabet range onto its six-bit value.
  localparam logic [7:0] LOWER_OFFSET = 8'd71;  // 'a' - 26
  localparam logic [7:0] DIGIT_OFFSET = 8'd4;   // 52 - '0'
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  // One classified character as it travels from the front end to the back end.
  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] sextet;
    logic       last;
  } beat_t;

  function automatic beat_t classify(input logic [7:0] ch, input logic last);
    beat_t b;
    b.kind   = KIND_OTHER;
    b.sextet = '0;
    b.last   = last;
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      b.kind   = KIND_ALPHA;
      b.sextet = 6'(ch - CHAR_UPPER_A);
    end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      b.kind   = KIND_ALPHA;
      b.sextet = 6'(ch - LOWER_OFFSET);
    end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
      b.kind   = KIND_ALPHA;
      b.sextet = 6'(ch + DIGIT_OFFSET);
    end else if (ch == CHAR_PLUS) begin
      b.kind   = KIND_ALPHA;
      b.sextet = SEXTET_PLUS;
    end else if (ch == CHAR_SLASH) begin
      b.kind   = KIND_ALPHA;
      b.sextet = SEXTET_SLASH;
    end else if (ch == CHAR_EQUALS) begin
      b.kind = KIND_PAD;
    end else if (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_LF ||
                 ch == CHAR_FF || ch == CHAR_CR) begin
      b.kind = KIND_BLANK;
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
// Front end of the Base64 decoder: accepts characters and classifies them.
module b64d_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char,
  input  logic              end_of_message,
  output logic              push,
  output b64d_pkg::beat_t   push_beat,
  input  logic              queue_full
);

  // A beat is taken whenever the queue has a free entry.
  assign in_ready  = !queue_full;
  assign push      = in_valid && !queue_full;
  assign push_beat = b64d_pkg::classify(in_char, end_of_message);

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// Short queue of classified beats between the front end and the back end.
module b64d_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64d_pkg::beat_t  push_beat,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output b64d_pkg::beat_t  head_beat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64d_pkg::beat_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_beat  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count beyond its depth");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/b64d_back.sv =====
// Back end of the Base64 decoder: group state, byte assembly and the result register.
module b64d_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  b64d_pkg::beat_t  head_beat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             bad_input,
  output logic             message_done
);

  logic [2:0] position;
  logic [5:0] leftover;
  logic       drop;

  logic [2:0] pos;
  logic [2:0] position_next;
  logic [5:0] leftover_next;
  logic       drop_next;
  logic [7:0] byte_next;
  logic       got_byte;
  logic       bad;
  logic       emit;
  logic       is_pad;

  // The head beat is consumed whenever the result register is free or being emptied.
  assign pop    = head_valid && (!out_valid || out_ready);
  assign is_pad = (head_beat.kind == b64d_pkg::KIND_PAD);

  always_comb begin
    pos           = (position > b64d_pkg::POS_SECOND_PAD) ? b64d_pkg::POS_FIRST : position;
    position_next = position;
    leftover_next = leftover;
    drop_next     = drop;
    byte_next     = '0;
    got_byte      = 1'b0;
    bad           = 1'b0;
    if (!drop && head_beat.kind != b64d_pkg::KIND_BLANK) begin
      if (pos == b64d_pkg::POS_SECOND_PAD) begin
        if (is_pad) begin
          position_next = b64d_pkg::POS_FIRST;
        end else begin
          bad = 1'b1;
        end
      end else if (pos == b64d_pkg::POS_THIRD && is_pad) begin
        position_next = b64d_pkg::POS_SECOND_PAD;
      end else if (pos == b64d_pkg::POS_FOURTH && is_pad) begin
        position_next = b64d_pkg::POS_FIRST;
      end else if (head_beat.kind != b64d_pkg::KIND_ALPHA) begin
        bad = 1'b1;
      end else begin
        case (pos)
          b64d_pkg::POS_SECOND: begin
            byte_next     = {leftover, head_beat.sextet[5:4]};
            leftover_next = {2'b00, head_beat.sextet[3:0]};
            got_byte      = 1'b1;
            position_next = b64d_pkg::POS_THIRD;
          end
          b64d_pkg::POS_THIRD: begin
            byte_next     = {leftover[3:0], head_beat.sextet[5:2]};
            leftover_next = {4'b0000, head_beat.sextet[1:0]};
            got_byte      = 1'b1;
            position_next = b64d_pkg::POS_FOURTH;
          end
          b64d_pkg::POS_FOURTH: begin
            byte_next     = {leftover[1:0], head_beat.sextet};
            leftover_next = '0;
            got_byte      = 1'b1;
            position_next = b64d_pkg::POS_FIRST;
          end
          default: begin
            leftover_next = head_beat.sextet;
            position_next = b64d_pkg::POS_SECOND;
          end
        endcase
      end
      if (bad) begin
        drop_next = 1'b1;
      end
    end
    if (head_beat.last) begin
      position_next = b64d_pkg::POS_FIRST;
      leftover_next = '0;
      drop_next     = 1'b0;
    end
    emit = got_byte || bad || head_beat.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= b64d_pkg::POS_FIRST;
      leftover  <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        position <= position_next;
        leftover <= leftover_next;
        drop     <= drop_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte     <= byte_next;
      byte_valid   <= got_byte;
      bad_input    <= bad;
      message_done <= head_beat.last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) position <= b64d_pkg::POS_SECOND_PAD)
    else $error("group position left its legal range");
  assert property (@(posedge clk) disable iff (rst)
      pop && head_beat.last |=> position == b64d_pkg::POS_FIRST && leftover == '0 && !drop)
    else $error("state not cleared after the end of a message");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !(byte_valid && bad_input))
    else $error("result carries both a byte and an error");
  assert property (@(posedge clk) disable iff (rst)
      pop && drop && !head_beat.last |-> !emit)
    else $error("result emitted while dropping the rest of a message");

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// Top level of the streaming Base64 decoder.
//
// The input channel (in_valid, in_ready, in_char, end_of_message) carries one
// ASCII character per beat, with end_of_message set on the last character of
// a message. The output channel (out_valid, out_ready, out_byte, byte_valid,
// bad_input, message_done) carries at most one result per input beat: a
// decoded byte, an error flag on the first bad character, and the end mark.
// Beats that only advance the decoder, such as whitespace or the first
// character of a group, give no result.
// A beat is classified on entry and written into a short queue at the edge
// that accepts it; the back end takes it from the queue once the result
// register is free or being emptied, and registers its result there. The
// block sustains one beat per clock cycle while the output side keeps taking
// results; the back end, which updates its group state as it takes each
// beat, sets that rate.
// When the receiver stalls, the result register holds its beat and the queue
// absorbs up to QUEUE_DEPTH further characters before in_ready falls.
// A synchronous reset empties the queue and the result register and returns
// the decoder to the start of a group with no error pending.
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       bad_input,
  output logic       message_done
);

  // Beats travel between the three parts in classified form.
  logic            push;
  b64d_pkg::beat_t push_beat;
  logic            queue_full;
  logic            pop;
  logic            head_valid;
  b64d_pkg::beat_t head_beat;

  // The front end maps each character to its class and six-bit value.
  b64d_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .end_of_message (end_of_message),
    .push           (push),
    .push_beat      (push_beat),
    .queue_full     (queue_full)
  );

  // The queue decouples acceptance from the back end's stalls.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_beat  (push_beat),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_beat  (head_beat)
  );

  // The back end tracks the group position and builds the result beats.
  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_beat    (head_beat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .bad_input    (bad_input),
    .message_done (message_done)
  );

endmodule
